// File: src/mlpg_pkg.sv
// ----------------------------------------------------------------------------
// mlpg_pkg
// Shared types for the midpoint line point generator: the command word
// from the controller to the datapath and the status word back.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpg_pkg;

	typedef struct packed {
		logic load;     // capture and mirror the endpoints
		logic setup;    // form deltas, decision and step increments
		logic advance;  // take one walk step
	} mlpg_cmd_t;

	typedef struct packed {
		logic last;     // current point ends the segment
		logic cut;      // current point ends it at the point limit
	} mlpg_status_t;

endpackage

`default_nettype wire

// File: src/mlpg_ctrl.sv
// ----------------------------------------------------------------------------
// mlpg_ctrl
// Sequencer for the line walk: takes a segment word, runs a setup step,
// then presents one point word per cycle while m_tready is high until the last one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpg_ctrl
	import mlpg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire mlpg_status_t status,
	output mlpg_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		cmd.load    = 1'b0;
		cmd.setup   = 1'b0;
		cmd.advance = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.setup, cmd.advance}))
		else $error("more than one datapath command at once");

	a_load_then_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.setup && !m_tvalid)
		else $error("setup cycle missing after segment load");
`endif

endmodule

`default_nettype wire

// File: src/mlpg_datapath.sv
// ----------------------------------------------------------------------------
// mlpg_datapath
// Walk registers for the midpoint line: mirrored position, end coordinate,
// decision variable, step increments and point counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpg_datapath
	import mlpg_pkg::*;
#(
	parameter int COORD_WIDTH = 12,
	parameter int MAX_POINTS  = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mlpg_cmd_t                     cmd,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output mlpg_status_t                       status
);

	localparam int WW = COORD_WIDTH + 1;
	localparam int DW = COORD_WIDTH + 2;
	localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_POINTS - 1);

	logic signed [WW-1:0] sx, sy, ex, ey;
	logic                 mir_x, mir_y;
	logic signed [WW-1:0] walk_x_q, walk_y_q, end_x_q, end_y_q, walk_end_q;
	logic signed [DW-1:0] decision_q, step_straight_q, step_diagonal_q;
	logic [1:0]           mirror_q;
	logic                 x_major_q;
	logic [CW-1:0]        cnt_q;

	logic signed [WW-1:0] dx, dy, major, out_x, out_y;
	logic signed [DW-1:0] dxe, dye;
	logic                 x_major;
	logic                 at_end;
	logic                 dec_le0;

	assign sx    = {start_x[COORD_WIDTH-1], start_x};
	assign sy    = {start_y[COORD_WIDTH-1], start_y};
	assign ex    = {end_x[COORD_WIDTH-1], end_x};
	assign ey    = {end_y[COORD_WIDTH-1], end_y};
	assign mir_x = start_x > end_x;
	assign mir_y = start_y > end_y;

	assign dx      = end_x_q - walk_x_q;
	assign dy      = end_y_q - walk_y_q;
	assign dxe     = {dx[WW-1], dx};
	assign dye     = {dy[WW-1], dy};
	assign x_major = dx >= dy;

	assign major   = x_major_q ? walk_x_q : walk_y_q;
	assign at_end  = major >= walk_end_q;
	assign dec_le0 = decision_q[DW-1] || (decision_q == '0);

	assign status.last = at_end || (cnt_q == CNT_LAST);
	assign status.cut  = !at_end && (cnt_q == CNT_LAST);

	assign out_x   = mirror_q[0] ? -walk_x_q : walk_x_q;
	assign out_y   = mirror_q[1] ? -walk_y_q : walk_y_q;
	assign point_x = out_x[COORD_WIDTH-1:0];
	assign point_y = out_y[COORD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q        <= '0;
			walk_y_q        <= '0;
			end_x_q         <= '0;
			end_y_q         <= '0;
			walk_end_q      <= '0;
			decision_q      <= '0;
			step_straight_q <= '0;
			step_diagonal_q <= '0;
			mirror_q        <= '0;
			x_major_q       <= 1'b0;
			cnt_q           <= '0;
		end else if (cmd.load) begin
			walk_x_q <= mir_x ? -sx : sx;
			walk_y_q <= mir_y ? -sy : sy;
			end_x_q  <= mir_x ? -ex : ex;
			end_y_q  <= mir_y ? -ey : ey;
			mirror_q <= {mir_y, mir_x};
		end else if (cmd.setup) begin
			x_major_q <= x_major;
			cnt_q     <= '0;
			if (x_major) begin
				decision_q      <= (dye <<< 1) - dxe;
				step_straight_q <= dye <<< 1;
				step_diagonal_q <= (dye - dxe) <<< 1;
				walk_end_q      <= end_x_q;
			end else begin
				decision_q      <= (dxe <<< 1) - dye;
				step_straight_q <= dxe <<< 1;
				step_diagonal_q <= (dxe - dye) <<< 1;
				walk_end_q      <= end_y_q;
			end
		end else if (cmd.advance) begin
			cnt_q <= cnt_q + CW'(1);
			if (dec_le0) begin
				decision_q <= decision_q + step_straight_q;
				if (x_major_q) begin
					walk_x_q <= walk_x_q + WW'(1);
				end else begin
					walk_y_q <= walk_y_q + WW'(1);
				end
			end else begin
				decision_q <= decision_q + step_diagonal_q;
				walk_x_q   <= walk_x_q + WW'(1);
				walk_y_q   <= walk_y_q + WW'(1);
			end
		end
	end

`ifndef SYNTH
	a_setup_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |=> cnt_q == '0)
		else $error("point count not cleared at setup");

	a_advance_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("point count did not advance with the walk");

	a_major_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> (major == $past(major) + WW'(1)))
		else $error("major axis did not step by one");
`endif

endmodule

`default_nettype wire

// File: src/midpoint_line_point_generator.sv
// ----------------------------------------------------------------------------
// midpoint_line_point_generator
// Walks a line segment between two signed pixel endpoints with the midpoint
// decision variable; streams every pixel, ends included, up to MAX_POINTS.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                 | tlast      | tuser
//  s_*     | in  | start_x, start_y, end_x, end_y     | -          | -
//  m_*     | out | point_x, point_y                   | last_point | truncated
//
//  A segment word is taken only while no walk is running. A setup step
//  follows, then one point word per cycle while m_tready is high, with the
//  point count capped at MAX_POINTS, paced by the single walk step register set.
//  A stalled m_tready holds the current point and the walk.
//  arst_n returns the block to idle; a walk in progress is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_point_generator
	import mlpg_pkg::*;
#(
	parameter int COORD_WIDTH = 12,
	parameter int MAX_POINTS  = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// start_x, start_y, end_x, end_y, zero fill
	input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// point_x, point_y, zero fill
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
	output logic                                        m_tlast,
	// truncated
	output logic                                        m_tuser
);

	localparam int OUT_W = ((2*COORD_WIDTH+7)/8)*8;

	mlpg_cmd_t                      cmd;
	mlpg_status_t                   status;
	logic signed [COORD_WIDTH-1:0]  point_x;
	logic signed [COORD_WIDTH-1:0]  point_y;

	mlpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mlpg_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAX_POINTS  (MAX_POINTS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.start_x (s_tdata[COORD_WIDTH-1:0]),
		.start_y (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.end_x   (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
		.end_y   (s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
		.point_x (point_x),
		.point_y (point_y),
		.status  (status)
	);

	assign m_tdata = OUT_W'({point_y, point_x});
	assign m_tlast = status.last;
	assign m_tuser = status.cut;

endmodule

`default_nettype wire

// File: dv/tb_midpoint_line_point_generator.sv
// ----------------------------------------------------------------------------
// tb_midpoint_line_point_generator
// Self-checking bench for the midpoint line point generator. Segments go in
// as single words on the slave stream, and every pixel word on the master
// stream is checked against an in-bench line walker. First come hand-picked
// segments: degenerate points, every quadrant, axis ties, decision ties and
// the point-limit boundary. Then random segments run under several
// handshake idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midpoint_line_point_generator;

	localparam int COORD_W         = 12;
	localparam int MAX_PTS         = 64;
	localparam int RANDOM_SEGMENTS = 196;
	localparam int FLOW_SPAN       = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int LIMIT_CYCLES    = 1000000;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		bit     typed;  // single-pixel result known by inspection
	} seg_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		bit     last;
		bit     cut;
	} pixel_t;

	typedef enum int {
		FREE_FLOW,
		SENDER_IDLE,
		RECEIVER_STALL,
		BOTH_IDLE,
		OUTPUT_HOLD
	} flow_t;

	localparam seg_t DIRECTED [24] = '{
		'{0, 0, 0, 0, 1'b1},
		'{-2048, -2048, -2048, -2048, 1'b1},
		'{2047, 2047, 2047, 2047, 1'b1},
		'{2047, -2048, 2047, -2048, 1'b1},
		'{0, 0, 5, 2, 1'b0},
		'{0, 0, 2, 5, 1'b0},
		'{5, 2, 0, 0, 1'b0},
		'{-3, 4, 3, -4, 1'b0},
		'{4, -7, -4, 7, 1'b0},
		'{0, 0, 6, 6, 1'b0},
		'{3, -3, -3, 3, 1'b0},
		'{0, 0, 2, 1, 1'b0},
		'{0, 0, 4, 2, 1'b0},
		'{0, 0, 63, 0, 1'b0},
		'{0, 0, 64, 0, 1'b0},
		'{0, 0, 0, 63, 1'b0},
		'{10, 20, 10, -60, 1'b0},
		'{-2048, -2048, 2047, 2047, 1'b0},
		'{2047, 2047, -2048, -2048, 1'b0},
		'{-2048, 2047, 2047, -2048, 1'b0},
		'{2047, -2048, -2048, 2047, 1'b0},
		'{-2048, 0, 2047, 1, 1'b0},
		'{-1, -1, 1, 1, 1'b0},
		'{2040, 2047, 2047, 2040, 1'b0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	pixel_t pending_pixels [$];
	pixel_t want_pixel;
	pixel_t got_pixel;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int errors         = 0;
	int segments_sent  = 0;
	int cut_segments   = 0;
	int pixels_checked = 0;

	midpoint_line_point_generator #(
		.COORD_WIDTH(COORD_W),
		.MAX_POINTS (MAX_PTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // start_x, start_y, end_x, end_y
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // point_x, point_y
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)    // truncated
	);

	always #2 clk = ~clk;

	// Walk the segment in mirrored space and queue every pixel it yields.
	function automatic void plot_segment(input seg_t seg);
		int  ax, ay, bx, by, dx, dy;
		int  decision, inc_straight, inc_diag, stop, count;
		bit  flip_x, flip_y, x_major, at_end, cut, done;
		pixel_t p;
		flip_x = seg.sx > seg.ex;
		flip_y = seg.sy > seg.ey;
		ax = flip_x ? -int'(seg.sx) : int'(seg.sx);
		bx = flip_x ? -int'(seg.ex) : int'(seg.ex);
		ay = flip_y ? -int'(seg.sy) : int'(seg.sy);
		by = flip_y ? -int'(seg.ey) : int'(seg.ey);
		dx = bx - ax;
		dy = by - ay;
		x_major = dx >= dy;
		if (x_major) begin
			decision     = 2 * dy - dx;
			inc_straight = 2 * dy;
			inc_diag     = 2 * (dy - dx);
			stop         = bx;
		end else begin
			decision     = 2 * dx - dy;
			inc_straight = 2 * dx;
			inc_diag     = 2 * (dx - dy);
			stop         = by;
		end
		count = 0;
		done  = 1'b0;
		while (!done) begin
			at_end = (x_major ? ax : ay) >= stop;
			cut    = !at_end && (count + 1 >= MAX_PTS);
			p.x    = coord_t'(flip_x ? -ax : ax);
			p.y    = coord_t'(flip_y ? -ay : ay);
			p.last = at_end || cut;
			p.cut  = cut;
			pending_pixels.push_back(p);
			count++;
			if (at_end || cut) begin
				done = 1'b1;
				if (cut)
					cut_segments++;
			end else begin
				if (decision <= 0) begin
					decision += inc_straight;
				end else begin
					decision += inc_diag;
					if (x_major)
						ay++;
					else
						ax++;
				end
				if (x_major)
					ax++;
				else
					ay++;
			end
		end
	endfunction

	function automatic seg_t random_segment();
		seg_t seg;
		int   kind, span;
		kind   = $urandom_range(99);
		span   = (kind < 60) ? 12 : 70;
		seg.sx = coord_t'($urandom_range(4095));
		seg.sy = coord_t'($urandom_range(4095));
		if (kind < 85) begin
			seg.ex = coord_t'(int'(seg.sx) + int'($urandom_range(2 * span)) - span);
			seg.ey = coord_t'(int'(seg.sy) + int'($urandom_range(2 * span)) - span);
		end else begin
			seg.ex = coord_t'($urandom_range(4095));
			seg.ey = coord_t'($urandom_range(4095));
		end
		seg.typed = 1'b0;
		return seg;
	endfunction

	task automatic send_segment(input seg_t seg);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {seg.ey, seg.ex, seg.sy, seg.sx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		segments_sent++;
		if (seg.typed)
			pending_pixels.push_back('{seg.sx, seg.sy, 1'b1, 1'b0});
		else
			plot_segment(seg);
	endtask

	// Check accepted pixel words and pace m_tready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_pixel = '{m_tdata[11:0], m_tdata[23:12], m_tlast, m_tuser};
			if (pending_pixels.size() == 0) begin
				$display("%0t: expected no word, got (%0d,%0d) last=%0b truncated=%0b",
					$time, got_pixel.x, got_pixel.y, got_pixel.last, got_pixel.cut);
				errors++;
			end else begin
				want_pixel = pending_pixels.pop_front();
				pixels_checked++;
				if (got_pixel.x !== want_pixel.x) begin
					$display("%0t: point_x expected %0d got %0d",
						$time, want_pixel.x, got_pixel.x);
					errors++;
				end
				if (got_pixel.y !== want_pixel.y) begin
					$display("%0t: point_y expected %0d got %0d",
						$time, want_pixel.y, got_pixel.y);
					errors++;
				end
				if (got_pixel.last !== want_pixel.last) begin
					$display("%0t: last_point expected %0b got %0b",
						$time, want_pixel.last, got_pixel.last);
					errors++;
				end
				if (got_pixel.cut !== want_pixel.cut) begin
					$display("%0t: truncated expected %0b got %0b",
						$time, want_pixel.cut, got_pixel.cut);
					errors++;
				end
			end
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		flow_t flow;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_segment(DIRECTED[i]);

		for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
			if (i % FLOW_SPAN == 0) begin
				flow = flow_t'(i / FLOW_SPAN);
				case (flow)
					FREE_FLOW: begin
						send_idle_pct  = 0;
						recv_stall_pct = 0;
					end
					SENDER_IDLE: begin
						send_idle_pct  = 70;
						recv_stall_pct = 0;
					end
					RECEIVER_STALL: begin
						send_idle_pct  = 0;
						recv_stall_pct = 70;
					end
					BOTH_IDLE: begin
						send_idle_pct  = 9;
						recv_stall_pct = 9;
					end
					default: begin
						send_idle_pct  = 0;
						recv_stall_pct = 0;
						hold_requests++;
					end
				endcase
			end
			send_segment(random_segment());
		end

		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (MAX_PTS + 8) @(posedge clk);

		$display("Walked %0d segments, %0d of them cut at the point limit; %0d pixels checked.",
			segments_sent, cut_segments, pixels_checked);
		$display("Flow covered free running, idle sender, stalled receiver, light idling on");
		$display("both sides and a %0d-cycle output hold-off with the input backed up.",
			HOLD_CYCLES);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
src/mlpg_pkg.sv
src/mlpg_ctrl.sv
src/mlpg_datapath.sv
src/midpoint_line_point_generator.sv
dv/tb_midpoint_line_point_generator.sv
